// ----- sv/opd_pkg.sv -----
// Package for the OpenPGP packet deframer: phase and result codes, the result
// record, the tag classification helpers and the post-header phase helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package opd_pkg;

	// Widest body length that a header may carry (16 .. 32)
	localparam int LENGTH_WIDTH = 32;
	localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF >> (32 - LENGTH_WIDTH);

	// Output tdata width
	localparam int TDATA_W = 56;

	typedef enum logic [2:0] {
		PH_TAG       = 3'd0,
		PH_LEN_FIRST = 3'd1,
		PH_LEN_MORE  = 3'd2,
		PH_BODY      = 3'd3,
		PH_SKIP      = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_BODY   = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_FIRST_BIT = 3'd1;
	localparam logic [2:0] ERR_LENGTH    = 3'd2;
	localparam logic [2:0] ERR_UNKNOWN   = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED = 3'd4;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  tag;
		logic        new_fmt;
		logic [31:0] len;
		logic        partial;
		logic [7:0]  body_byte;
		logic        last;
		logic [2:0]  err;
	} result_t;

	// Tags that may carry a partial length
	function automatic logic partial_allowed(input logic [5:0] tag, input logic new_fmt);
		logic ok;
		ok = (tag == 6'd8) || (tag == 6'd9) || (tag == 6'd11) || (new_fmt && (tag == 6'd18));
		return ok;
	endfunction

	function automatic logic tag_known(input logic [5:0] tag);
		logic ok;
		ok = ((tag >= 6'd1) && (tag <= 6'd14)) || ((tag >= 6'd17) && (tag <= 6'd19));
		return ok;
	endfunction

	// Phase after a complete header
	function automatic phase_t header_done_phase(input logic stream_end, input logic partial,
			input logic len_zero, input logic known);
		phase_t ph;
		if (stream_end || (!partial && len_zero)) begin
			ph = PH_TAG;
		end else if (known) begin
			ph = PH_BODY;
		end else begin
			ph = PH_SKIP;
		end
		return ph;
	endfunction

endpackage

`default_nettype wire

// ----- sv/openpgp_packet_deframer_top.sv -----
// OpenPGP packet deframer: one stream byte in, at most one header, body or
// error item out. Depends on opd_pkg.
//
//  - Slave channel s_*: one raw stream byte per item in s_tdata[7:0];
//    s_tlast marks the final byte of the stream.
//  - Master channel m_*: m_tuser carries the result kind (header, body
//    byte, error); m_tdata carries the decoded header fields, the body byte
//    and the error code; m_tlast marks the final body byte of a packet.
//  - Bytes short of completing a header give no item unless in error or at
//    stream end; body bytes of skipped (unknown-tag) packets give none; others give one.
//  - Path: an input item lands in the input register, is decoded there and
//    its result is loaded into the output register on m_* once the master
//    side has taken the previous result.
//  - Throughput: one item per cycle while the master side takes results; the
//    byte decode is a short stretch of compare and mux logic between the input
//    register and the output register, so nothing iterates.
//  - Stall: while m_tready is low a pending result holds on m_*; one more
//    item is taken into the input register, then s_tready drops.
//  - Reset (arst_n low): clear the valid flags of both registers, return to
//    expecting a tag byte and clear all header state.
`timescale 1ns / 1ps
`default_nettype none

module openpgp_packet_deframer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
	input  wire logic        s_tlast,   // stream_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [opd_pkg::TDATA_W-1:0] m_tdata, // [5:0] packet_tag, [6] is_new_format,
	                                             // [38:7] body_length, [39] is_partial,
	                                             // [47:40] body_byte, [50:48] error_code
	output logic [1:0]       m_tuser,   // [1:0] result_kind
	output logic             m_tlast    // last_of_packet
);
	import opd_pkg::*;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Deframer state
	phase_t      phase_q, phase_d;
	logic [5:0]  tag_q, tag_d;
	logic        nf_q, nf_d;
	logic [2:0]  left_q, left_d;
	logic [7:0]  first_q, first_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] body_left_q, body_left_d;
	logic        part_q, part_d;

	// Output register
	logic    out_valid_q;
	result_t out_q;

	result_t res_d;
	logic    emit_d;
	logic    out_free, fire;

	// Advance the decode stage when the output register can take its result
	assign out_free = !out_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	// Shared decode terms
	logic [5:0]  tag_now;
	logic [5:0]  tag_old;
	logic [31:0] acc_shift;
	logic [2:0]  left_dec;
	logic        more_done;
	logic        two_octet;
	logic [31:0] len_more;
	logic        too_wide;
	logic        body_last;
	logic        skip_done;

	assign tag_old   = {2'b00, byte_s1[5:2]};
	assign tag_now   = byte_s1[6] ? byte_s1[5:0] : tag_old;
	assign acc_shift = {acc_q[23:0], byte_s1};
	assign left_dec  = left_q - 3'd1;
	assign more_done = (left_dec == 3'd0);
	// First octet 192..223 is 110xxxxx: length = {xxxxx, second} + 192
	assign two_octet = nf_q && (first_q[7:5] == 3'b110);
	assign len_more  = two_octet ? (32'({first_q[4:0], byte_s1}) + 32'd192) : acc_shift;
	assign too_wide  = (len_more > LEN_MAX);
	assign body_last = part_q ? end_s1 : ((body_left_q <= 32'd1) || end_s1);
	assign skip_done = part_q ? end_s1 : ((body_left_q <= 32'd1) || end_s1);

	// Next state
	always_comb begin
		phase_d     = phase_q;
		tag_d       = tag_q;
		nf_d        = nf_q;
		left_d      = left_q;
		first_d     = first_q;
		acc_d       = acc_q;
		body_left_d = body_left_q;
		part_d      = part_q;
		case (phase_q)
			PH_TAG: begin
				phase_d = PH_TAG;
				part_d  = 1'b0;
				if (!byte_s1[7]) begin
					tag_d = 6'd0;
					nf_d  = 1'b0;
				end else begin
					nf_d  = byte_s1[6];
					tag_d = tag_now;
					acc_d = 32'd0;
					if (byte_s1[6]) begin
						phase_d = end_s1 ? PH_TAG : PH_LEN_FIRST;
					end else if (byte_s1[1:0] == 2'b11) begin
						if (partial_allowed(tag_old, 1'b0)) begin
							part_d      = 1'b1;
							body_left_d = 32'd0;
							phase_d     = header_done_phase(end_s1, 1'b1, 1'b1,
								tag_known(tag_old));
						end
					end else begin
						left_d  = 3'(3'd1 << byte_s1[1:0]);
						phase_d = end_s1 ? PH_TAG : PH_LEN_MORE;
					end
				end
			end
			PH_LEN_FIRST: begin
				first_d = byte_s1;
				if (byte_s1 < 8'd192) begin
					body_left_d = 32'(byte_s1);
					phase_d     = header_done_phase(end_s1, part_q, byte_s1 == 8'd0,
						tag_known(tag_q));
				end else if ((byte_s1 >= 8'd224) && (byte_s1 != 8'd255)) begin
					if (partial_allowed(tag_q, 1'b1)) begin
						part_d      = 1'b1;
						body_left_d = 32'(byte_s1);
						phase_d     = header_done_phase(end_s1, 1'b1, 1'b0,
							tag_known(tag_q));
					end else begin
						phase_d = PH_TAG;
						part_d  = 1'b0;
					end
				end else begin
					left_d = (byte_s1 == 8'd255) ? 3'd4 : 3'd1;
					acc_d  = 32'd0;
					if (end_s1) begin
						phase_d = PH_TAG;
						part_d  = 1'b0;
					end else begin
						phase_d = PH_LEN_MORE;
					end
				end
			end
			PH_LEN_MORE: begin
				acc_d  = acc_shift;
				left_d = left_dec;
				if (!more_done) begin
					if (end_s1) begin
						phase_d = PH_TAG;
						part_d  = 1'b0;
					end
				end else if (too_wide) begin
					phase_d = PH_TAG;
					part_d  = 1'b0;
				end else begin
					body_left_d = len_more;
					phase_d     = header_done_phase(end_s1, part_q, len_more == 32'd0,
						tag_known(tag_q));
				end
			end
			PH_BODY: begin
				if (!part_q) begin
					body_left_d = body_left_q - 32'd1;
				end
				if (body_last) begin
					phase_d = PH_TAG;
					part_d  = 1'b0;
				end
			end
			PH_SKIP: begin
				if (!part_q) begin
					body_left_d = body_left_q - 32'd1;
				end
				if (skip_done) begin
					phase_d = PH_TAG;
					if (part_q) begin
						part_d = 1'b0;
					end
				end
			end
			default: begin
				phase_d = PH_TAG;
			end
		endcase
	end

	// Result of the byte in the decode stage
	always_comb begin
		res_d  = '0;
		emit_d = 1'b0;
		case (phase_q)
			PH_TAG: begin
				if (!byte_s1[7]) begin
					emit_d     = 1'b1;
					res_d.kind = KIND_ERROR;
					res_d.err  = ERR_FIRST_BIT;
				end else if (byte_s1[6]) begin
					if (end_s1) begin
						emit_d        = 1'b1;
						res_d.kind    = KIND_ERROR;
						res_d.tag     = tag_now;
						res_d.new_fmt = 1'b1;
						res_d.err     = ERR_TRUNCATED;
					end
				end else begin
					emit_d     = (byte_s1[1:0] == 2'b11) || end_s1;
					res_d.kind = KIND_ERROR;
					res_d.tag  = tag_old;
					if (byte_s1[1:0] == 2'b11) begin
						if (!partial_allowed(tag_old, 1'b0)) begin
							res_d.err = ERR_LENGTH;
						end else begin
							res_d.partial = 1'b1;
							if (tag_known(tag_old)) begin
								res_d.kind = KIND_HEADER;
							end else begin
								res_d.err = ERR_UNKNOWN;
							end
						end
					end else begin
						res_d.err = ERR_TRUNCATED;
					end
				end
			end
			PH_LEN_FIRST: begin
				res_d.tag     = tag_q;
				res_d.new_fmt = nf_q;
				res_d.kind    = KIND_ERROR;
				if ((byte_s1 < 8'd192) ||
				    ((byte_s1 >= 8'd224) && (byte_s1 != 8'd255) &&
				     partial_allowed(tag_q, 1'b1))) begin
					emit_d        = 1'b1;
					res_d.len     = 32'(byte_s1);
					res_d.partial = (byte_s1 >= 8'd224) ? 1'b1 : part_q;
					if (tag_known(tag_q)) begin
						res_d.kind = KIND_HEADER;
					end else begin
						res_d.err = ERR_UNKNOWN;
					end
				end else if (byte_s1 >= 8'd224 && byte_s1 != 8'd255) begin
					emit_d    = 1'b1;
					res_d.err = ERR_LENGTH;
				end else if (end_s1) begin
					emit_d    = 1'b1;
					res_d.err = ERR_TRUNCATED;
				end
			end
			PH_LEN_MORE: begin
				res_d.tag     = tag_q;
				res_d.new_fmt = nf_q;
				res_d.kind    = KIND_ERROR;
				if (!more_done) begin
					emit_d    = end_s1;
					res_d.err = ERR_TRUNCATED;
				end else if (too_wide) begin
					emit_d    = 1'b1;
					res_d.err = ERR_LENGTH;
				end else begin
					emit_d        = 1'b1;
					res_d.len     = len_more;
					res_d.partial = part_q;
					if (tag_known(tag_q)) begin
						res_d.kind = KIND_HEADER;
					end else begin
						res_d.err = ERR_UNKNOWN;
					end
				end
			end
			PH_BODY: begin
				emit_d          = 1'b1;
				res_d.kind      = KIND_BODY;
				res_d.tag       = tag_q;
				res_d.new_fmt   = nf_q;
				res_d.partial   = part_q;
				res_d.body_byte = byte_s1;
				res_d.last      = body_last;
			end
			default: begin
				emit_d = 1'b0;
			end
		endcase
	end

	// Hold state until the decode stage fires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TAG;
			tag_q       <= 6'd0;
			nf_q        <= 1'b0;
			left_q      <= 3'd0;
			first_q     <= 8'd0;
			acc_q       <= 32'd0;
			body_left_q <= 32'd0;
			part_q      <= 1'b0;
		end else if (fire) begin
			phase_q     <= phase_d;
			tag_q       <= tag_d;
			nf_q        <= nf_d;
			left_q      <= left_d;
			first_q     <= first_d;
			acc_q       <= acc_d;
			body_left_q <= body_left_d;
			part_q      <= part_d;
		end
	end

	// Output register: load a new result, or drop the one just taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && emit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit_d) begin
			out_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {5'd0, out_q.err, out_q.body_byte, out_q.partial, out_q.len,
		out_q.new_fmt, out_q.tag};

	// Only error items carry an error code
	a_err_only_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != KIND_ERROR)) |-> (m_tdata[50:48] == ERR_NONE))
		else $error("error code set on a non-error item");

	// The packet-end mark appears on body items only
	a_last_on_body: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == KIND_BODY))
		else $error("last mark on a non-body item");

	// The final byte of a stream always leaves the deframer expecting a tag byte
	a_end_to_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && end_s1) |=> (phase_q == PH_TAG))
		else $error("stream end did not return to tag phase");

endmodule

`default_nettype wire

// ----- bench/opd_stream_checker.sv -----
// Scoreboard for the OpenPGP packet deframer: watches both stream channels,
// predicts each result from the accepted bytes and compares field by field.
// Depends on opd_pkg for the phase, kind and error codes and the result record.
`timescale 1ns / 1ps

module opd_stream_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	input  wire logic                        s_tready,
	input  wire logic [7:0]                  s_tdata,
	input  wire logic                        s_tlast,
	input  wire logic                        m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic [opd_pkg::TDATA_W-1:0] m_tdata,
	input  wire logic [1:0]                  m_tuser,
	input  wire logic                        m_tlast,
	output int                               failures,
	output int                               pending,
	output int                               header_count,
	output int                               body_count,
	output int                               error_count
);
	import opd_pkg::*;

	localparam logic [1:0] OLD_INDETERMINATE = 2'd3;

	// Parser state, mirrored from the byte stream
	phase_t      parse_ph;
	logic [5:0]  hdr_tag;
	logic        hdr_new;
	logic [2:0]  octets_due;
	logic [7:0]  lead_octet;
	logic [31:0] len_acc;
	logic [31:0] body_due;
	logic        runs_to_end;

	result_t     result_q[$];

	function automatic logic may_be_partial(input logic [5:0] t, input logic nf);
		return (t == 6'd8) || (t == 6'd9) || (t == 6'd11) || (nf && t == 6'd18);
	endfunction

	function automatic logic is_known_tag(input logic [5:0] t);
		return (t >= 6'd1 && t <= 6'd14) || (t >= 6'd17 && t <= 6'd19);
	endfunction

	task automatic queue_result(input kind_t k, input logic [31:0] l, input logic p,
			input logic [7:0] b, input logic lst, input logic [2:0] e);
		result_t r;
		r.kind      = k;
		r.tag       = hdr_tag;
		r.new_fmt   = hdr_new;
		r.len       = l;
		r.partial   = p;
		r.body_byte = b;
		r.last      = lst;
		r.err       = e;
		result_q.insert(result_q.size(), r);
	endtask

	task automatic raise_error(input logic [2:0] code);
		queue_result(KIND_ERROR, 32'd0, 1'b0, 8'd0, 1'b0, code);
		parse_ph    = PH_TAG;
		runs_to_end = 1'b0;
	endtask

	// Header complete: report it (or the unknown tag) and pick the next phase
	task automatic close_header(input logic [31:0] l, input logic fin);
		logic known;
		known = is_known_tag(hdr_tag);
		if (known) begin
			queue_result(KIND_HEADER, l, runs_to_end, 8'd0, 1'b0, ERR_NONE);
		end else begin
			queue_result(KIND_ERROR, l, runs_to_end, 8'd0, 1'b0, ERR_UNKNOWN);
		end
		body_due = l;
		if (fin || (!runs_to_end && l == 32'd0)) begin
			parse_ph = PH_TAG;
		end else if (known) begin
			parse_ph = PH_BODY;
		end else begin
			parse_ph = PH_SKIP;
		end
	endtask

	task automatic decode_stream_byte(input logic [7:0] b, input logic fin);
		logic [32:0] full_len;
		logic        lst;
		case (parse_ph)
			PH_TAG: begin
				if (!b[7]) begin
					hdr_tag = 6'd0;
					hdr_new = 1'b0;
					raise_error(ERR_FIRST_BIT);
				end else begin
					hdr_new     = b[6];
					runs_to_end = 1'b0;
					len_acc     = 32'd0;
					if (hdr_new) begin
						hdr_tag = b[5:0];
						if (fin) raise_error(ERR_TRUNCATED);
						else parse_ph = PH_LEN_FIRST;
					end else begin
						hdr_tag = {2'b00, b[5:2]};
						if (b[1:0] == OLD_INDETERMINATE) begin
							if (!may_be_partial(hdr_tag, 1'b0)) begin
								raise_error(ERR_LENGTH);
							end else begin
								runs_to_end = 1'b1;
								close_header(32'd0, fin);
							end
						end else begin
							octets_due = 3'd1 << b[1:0];
							if (fin) raise_error(ERR_TRUNCATED);
							else parse_ph = PH_LEN_MORE;
						end
					end
				end
			end
			PH_LEN_FIRST: begin
				lead_octet = b;
				if (b < 8'd192) begin
					close_header({24'd0, b}, fin);
				end else if (b >= 8'd224 && b != 8'd255) begin
					if (!may_be_partial(hdr_tag, 1'b1)) begin
						raise_error(ERR_LENGTH);
					end else begin
						runs_to_end = 1'b1;
						close_header({24'd0, b}, fin);
					end
				end else begin
					octets_due = (b == 8'd255) ? 3'd4 : 3'd1;
					len_acc    = 32'd0;
					if (fin) raise_error(ERR_TRUNCATED);
					else parse_ph = PH_LEN_MORE;
				end
			end
			PH_LEN_MORE: begin
				len_acc    = {len_acc[23:0], b};
				octets_due = octets_due - 3'd1;
				if (octets_due != 3'd0) begin
					if (fin) raise_error(ERR_TRUNCATED);
				end else begin
					// two-octet new-format lengths are biased by 192
					if (hdr_new && lead_octet >= 8'd192 && lead_octet < 8'd224) begin
						full_len = ({25'd0, lead_octet} - 33'd192) * 33'd256
							+ {25'd0, b} + 33'd192;
					end else begin
						full_len = {1'b0, len_acc};
					end
					if (full_len > {1'b0, LEN_MAX}) raise_error(ERR_LENGTH);
					else close_header(full_len[31:0], fin);
				end
			end
			PH_BODY: begin
				if (runs_to_end) begin
					lst = fin;
				end else begin
					lst      = (body_due <= 32'd1) || fin;
					body_due = body_due - 32'd1;
				end
				queue_result(KIND_BODY, 32'd0, runs_to_end, b, lst, ERR_NONE);
				if (lst) begin
					parse_ph    = PH_TAG;
					runs_to_end = 1'b0;
				end
			end
			PH_SKIP: begin
				if (runs_to_end) begin
					if (fin) begin
						parse_ph    = PH_TAG;
						runs_to_end = 1'b0;
					end
				end else begin
					if (body_due <= 32'd1 || fin) parse_ph = PH_TAG;
					body_due = body_due - 32'd1;
				end
			end
			default: parse_ph = PH_TAG;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
			failures++;
		end
	endtask

	task automatic check_result();
		result_t want;
		if (result_q.size() == 0) begin
			$error("result with no expectation waiting: kind %0d", m_tuser);
			failures++;
		end else begin
			want = result_q.pop_front();
			check_field("result_kind", want.kind, m_tuser);
			check_field("packet_tag", want.tag, m_tdata[5:0]);
			check_field("is_new_format", want.new_fmt, m_tdata[6]);
			check_field("body_length", want.len, m_tdata[38:7]);
			check_field("is_partial", want.partial, m_tdata[39]);
			check_field("body_byte", want.body_byte, m_tdata[47:40]);
			check_field("error_code", want.err, m_tdata[50:48]);
			check_field("tdata_padding", 32'd0, m_tdata[opd_pkg::TDATA_W-1:51]);
			check_field("last_of_packet", want.last, m_tlast);
			case (want.kind)
				KIND_HEADER: header_count++;
				KIND_BODY:   body_count++;
				default:     error_count++;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_ph     = PH_TAG;
			hdr_tag      = 6'd0;
			hdr_new      = 1'b0;
			octets_due   = 3'd0;
			lead_octet   = 8'd0;
			len_acc      = 32'd0;
			body_due     = 32'd0;
			runs_to_end  = 1'b0;
			result_q.delete();
			failures     = 0;
			pending      = 0;
			header_count = 0;
			body_count   = 0;
			error_count  = 0;
		end else begin
			if (m_tvalid && m_tready) check_result();
			if (s_tvalid && s_tready) decode_stream_byte(s_tdata, s_tlast);
			pending = result_q.size();
		end
	end

endmodule

// ----- bench/tb.sv -----
// Top of the deframer bench: clock, reset, byte-stream stimulus and the
// output-side ready pattern. Depends on opd_pkg, the deframer and opd_stream_checker.
`timescale 1ns / 1ps

module tb;
	import opd_pkg::*;

	localparam int         ITEM_GOAL      = 950;
	localparam int         LONG_HOLD      = 300;
	localparam logic [1:0] OLD_LEN_ONE    = 2'd0;
	localparam logic [1:0] OLD_LEN_INDET  = 2'd3;
	localparam logic [7:0] NEW_LEN_FIVE   = 8'd255;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	int                  failures;
	int                  pending;
	int                  header_count;
	int                  body_count;
	int                  error_count;

	int                  bytes_sent;
	bit                  src_idle;   // random gaps between input items
	bit                  sink_idle;  // random stalls on the result side
	bit                  hold_long;  // request one long result-side stall

	openpgp_packet_deframer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	opd_stream_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.failures     (failures),
		.pending      (pending),
		.header_count (header_count),
		.body_count   (body_count),
		.error_count  (error_count)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Offer one byte at a falling edge, optionally after a random gap, and
	// hold it until the rising edge that takes it.
	task automatic push_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = 0;
		if (src_idle && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// Stop offering and wait until every predicted result has come out.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Pick a tag the block knows; for the old format only tags up to 15 fit.
	function automatic logic [5:0] pick_known_tag(input logic newf);
		int r;
		if (!newf) return 6'($urandom_range(1, 14));
		r = $urandom_range(0, 16);
		return (r < 14) ? 6'(r + 1) : 6'(r + 3);
	endfunction

	// Build one packet and send it. With cut set, drop the tail of the
	// header and end the stream inside it.
	task automatic send_packet(input bit cut);
		logic [8:0]  pk[$];
		logic        newf;
		logic [5:0]  tg;
		logic [1:0]  lt;
		logic [31:0] blen;
		logic [31:0] v;
		logic [7:0]  f;
		logic [7:0]  s;
		logic        part;
		int          sel;
		int          nb;
		int          nbody;
		int          keep;
		newf = 1'($urandom_range(0, 1));
		part = 1'b0;
		blen = 32'd0;
		sel  = $urandom_range(0, 9);
		if ($urandom_range(0, 11) == 0) begin
			// unknown tag: its body is skipped silently
			if (newf) begin
				case ($urandom_range(0, 2))
					0:       tg = 6'd0;
					1:       tg = 6'($urandom_range(15, 16));
					default: tg = 6'($urandom_range(20, 63));
				endcase
			end else begin
				tg = $urandom_range(0, 1) ? 6'd15 : 6'd0;
			end
		end else begin
			tg = pick_known_tag(newf);
		end
		// partial lengths: mostly on tags that allow them
		if ((newf && sel >= 8) || (!newf && sel >= 7)) begin
			part = 1'b1;
			if ($urandom_range(0, 9) != 0) begin
				case ($urandom_range(0, newf ? 3 : 2))
					0:       tg = 6'd8;
					1:       tg = 6'd9;
					2:       tg = 6'd11;
					default: tg = 6'd18;
				endcase
			end
		end
		if (newf) begin
			pk.insert(pk.size(), {1'b0, 2'b11, tg});
			if (part) begin
				pk.insert(pk.size(), {1'b0, 8'($urandom_range(224, 254))});
			end else if (sel <= 4) begin
				blen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 191) : $urandom_range(0, 8);
				pk.insert(pk.size(), {1'b0, blen[7:0]});
			end else if (sel <= 6) begin
				f = 8'($urandom_range(192, 223));
				s = 8'($urandom_range(0, 255));
				blen = (32'(f) - 32'd192) * 32'd256 + 32'(s) + 32'd192;
				pk.insert(pk.size(), {1'b0, f});
				pk.insert(pk.size(), {1'b0, s});
			end else begin
				blen = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : $urandom();
				pk.insert(pk.size(), {1'b0, NEW_LEN_FIVE});
				for (int i = 3; i >= 0; i--) pk.insert(pk.size(), {1'b0, blen[8*i +: 8]});
			end
		end else begin
			if (part) begin
				lt = OLD_LEN_INDET;
			end else begin
				lt = (sel <= 2) ? OLD_LEN_ONE : 2'((sel <= 4) ? 1 : 2);
			end
			pk.insert(pk.size(), {1'b0, 2'b10, tg[3:0], lt});
			if (!part) begin
				nb = 1 << lt;
				v  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : $urandom();
				blen = (nb == 1) ? {24'd0, v[7:0]} : (nb == 2) ? {16'd0, v[15:0]} : v;
				for (int i = nb - 1; i >= 0; i--) pk.insert(pk.size(), {1'b0, blen[8*i +: 8]});
			end
		end
		if (cut) begin
			// end the stream somewhere inside the header
			keep = (pk.size() > 1) ? $urandom_range(1, pk.size() - 1) : 1;
			while (pk.size() > keep) void'(pk.pop_back());
			pk[pk.size() - 1][8] = 1'b1;
		end else if (part || blen > 32'd8) begin
			// open-ended or long body: cut it short with the stream end
			nbody = $urandom_range(0, 6);
			for (int i = 0; i < nbody; i++) begin
				pk.insert(pk.size(), {1'b0, 8'($urandom_range(0, 255))});
			end
			pk[pk.size() - 1][8] = 1'b1;
		end else begin
			for (int i = 0; i < int'(blen); i++) begin
				pk.insert(pk.size(), {1'b0, 8'($urandom_range(0, 255))});
			end
			if ($urandom_range(0, 3) == 0) pk[pk.size() - 1][8] = 1'b1;
		end
		foreach (pk[i]) push_byte(pk[i][7:0], pk[i][8]);
	endtask

	// Result side: random stall bursts, and one long hold when asked for it.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_long = 1'b0;
				m_tready <= 1'b1;
			end else if (sink_idle && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Safety net against a hung handshake
	initial begin
		#1_000_000;
		$display("Timeout: results still outstanding or input stalled");
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		s_tvalid   = 1'b0;
		s_tdata    = 8'd0;
		s_tlast    = 1'b0;
		arst_n     = 1'b0;
		bytes_sent = 0;
		src_idle   = 1'b1;
		sink_idle  = 1'b1;
		hold_long  = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a set of header shapes and one of each error code
		push_byte(8'h00, 1'b0);   // first bit clear
		push_byte(8'h88, 1'b0);   // old format, tag 2, one length octet
		push_byte(8'h02, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);   // final body byte by count
		push_byte(8'hFF, 1'b0);   // new format, tag 63: unknown, body skipped
		push_byte(8'h01, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'hC2, 1'b0);   // zero length: header only
		push_byte(8'h00, 1'b0);
		push_byte(8'hA3, 1'b0);   // old indeterminate on tag 8
		push_byte(8'h55, 1'b0);
		push_byte(8'hAA, 1'b1);   // stream end closes the body
		push_byte(8'hC2, 1'b0);   // partial length on a tag that may not have one
		push_byte(8'hE0, 1'b0);
		push_byte(8'hC5, 1'b1);   // stream ends right after the tag byte
		push_byte(8'hD2, 1'b0);   // five-octet length, all ones
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);   // body cut by stream end
		push_byte(8'hCB, 1'b0);   // largest two-octet length
		push_byte(8'hDF, 1'b0);
		push_byte(8'hFF, 1'b1);   // header on the final byte: no body
		drain_results();

		// Random: mostly well-formed packets, some noise and cut headers
		while (bytes_sent < ITEM_GOAL) begin
			// no idling for a stretch in the middle and over the last part
			src_idle  = !((bytes_sent >= 250 && bytes_sent < 350) || bytes_sent >= 800);
			sink_idle = src_idle;
			if (bytes_sent >= 400 && bytes_sent < 420 && !hold_long) hold_long = 1'b1;
			if (bytes_sent >= 600 && bytes_sent < 610) drain_results();
			case ($urandom_range(0, 19))
				0:       send_packet(1'b1);
				1: begin
					// junk bytes, sometimes ending the stream
					repeat ($urandom_range(1, 4))
						push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
				end
				2:       push_byte(8'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
				default: send_packet(1'b0);
			endcase
		end

		drain_results();
		repeat (6) @(negedge clk);
		$display("Covered %0d stream bytes: %0d headers, %0d body bytes, %0d error items",
			bytes_sent, header_count, body_count, error_count);
		$display("including a long result-side stall and drained pauses on the input side.");
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
